// ----- src/pset_pkg.sv -----
// Shared types and constants for the profile sample event table.
// No dependencies; imported by the controller, datapath and top level.
`default_nettype none

package pset_pkg;

  localparam int TIMERS_DEF = 64;
  localparam int NS_PER_US  = 1000;
  localparam int DIV_DIGITS = 3;

  typedef enum logic [3:0] {
    CMD_REG     = 4'd0,
    CMD_REGEV   = 4'd1,
    CMD_ACC     = 4'd2,
    CMD_AUX     = 4'd3,
    CMD_LATCH1  = 4'd4,
    CMD_LATCHALL= 4'd5,
    CMD_ARM     = 4'd6,
    CMD_PUB     = 4'd7,
    CMD_ACK     = 4'd8,
    CMD_READREC = 4'd9,
    CMD_READEV  = 4'd10
  } cmd_t;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_DECODE,
    ST_READ,
    ST_EXEC,
    ST_DIV,
    ST_WRITE
  } state_t;

  // One table entry as held in memory
  typedef struct packed {
    logic        registered;
    logic        event_registered;
    logic        armed;
    logic        mbox_available;
    logic        mbox_overrun;
    logic [47:0] total_ns;
    logic [31:0] pend_inv;
    logic [39:0] pend_aux;
    logic [47:0] min_tick;
    logic [31:0] rec_seq;
    logic [38:0] rec_us;
    logic [31:0] rec_inv;
    logic [39:0] rec_aux;
    logic [31:0] mbox_seq;
    logic [31:0] mbox_sample_seq;
    logic [47:0] mbox_tick;
    logic [38:0] mbox_us;
    logic [31:0] mbox_inv;
    logic [39:0] mbox_aux;
  } entry_t;

  // Controller to datapath
  typedef struct packed {
    logic capture;
    logic rd_en;
    logic wr_en;
    logic clr;
    logic use_walk;
    logic div_start;
    logic emit;
    logic emit_zero;
  } ctl_cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic known;
    logic all;
    logic need_div;
    logic div_done;
  } ctl_sts_t;

endpackage

`default_nettype wire

// ----- src/pset_ram.sv -----
// Generic single-port RAM with registered read.
// No dependencies.
`default_nettype none

module pset_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 64,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic             clk,
  input  wire logic             we,
  input  wire logic             re,
  input  wire logic [AW-1:0]    addr,
  input  wire logic [WIDTH-1:0] wdata,
  output logic      [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write and registered read
  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    if (re) begin
      rdata <= mem[addr];
    end
  end

endmodule

`default_nettype wire

// ----- src/pset_ctrl.sv -----
// Controller state machine: clearing pass, command sequencing, latch-all walk.
// Depends on pset_pkg.
`default_nettype none

module pset_ctrl
  import pset_pkg::*;
#(
  parameter int TIMERS = TIMERS_DEF,
  localparam int AW = (TIMERS > 1) ? $clog2(TIMERS) : 1
) (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire logic          start,
  output logic               busy,
  input  wire ctl_sts_t      sts,
  output ctl_cmd_t           cmd,
  output logic [AW-1:0]      walk_addr
);

  localparam logic [AW-1:0] LAST = AW'(TIMERS - 1);

  state_t        state_r, state_nxt;
  logic [AW-1:0] walk_r, walk_nxt;

  // State and walk counter
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_CLEAR;
      walk_r  <= '0;
    end else begin
      state_r <= state_nxt;
      walk_r  <= walk_nxt;
    end
  end

  assign walk_addr = walk_r;
  assign busy      = (state_r != ST_IDLE);

  // Next state and commands
  always_comb begin
    state_nxt = state_r;
    walk_nxt  = walk_r;
    cmd       = '0;
    unique case (state_r)
      ST_CLEAR: begin
        cmd.use_walk = 1'b1;
        cmd.clr      = 1'b1;
        cmd.wr_en    = 1'b1;
        if (walk_r == LAST) begin
          walk_nxt  = '0;
          state_nxt = ST_IDLE;
        end else begin
          walk_nxt = walk_r + 1'b1;
        end
      end
      ST_IDLE: begin
        if (start) begin
          cmd.capture = 1'b1;
          state_nxt   = ST_DECODE;
        end
      end
      ST_DECODE: begin
        if (!sts.known) begin
          cmd.emit      = 1'b1;
          cmd.emit_zero = 1'b1;
          state_nxt     = ST_IDLE;
        end else if (sts.all) begin
          walk_nxt  = '0;
          state_nxt = ST_READ;
        end else begin
          cmd.rd_en = 1'b1;
          state_nxt = ST_EXEC;
        end
      end
      ST_READ: begin
        cmd.use_walk = 1'b1;
        cmd.rd_en    = 1'b1;
        state_nxt    = ST_EXEC;
      end
      ST_EXEC: begin
        cmd.use_walk = sts.all;
        if (sts.need_div) begin
          cmd.div_start = 1'b1;
          state_nxt     = ST_DIV;
        end else begin
          state_nxt = ST_WRITE;
        end
      end
      ST_DIV: begin
        cmd.use_walk = sts.all;
        if (sts.div_done) begin
          state_nxt = ST_WRITE;
        end
      end
      ST_WRITE: begin
        cmd.use_walk = sts.all;
        cmd.wr_en    = 1'b1;
        if (sts.all && (walk_r != LAST)) begin
          walk_nxt  = walk_r + 1'b1;
          state_nxt = ST_READ;
        end else begin
          cmd.emit  = 1'b1;
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

endmodule

`default_nettype wire

// ----- src/pset_dp.sv -----
// Datapath: command capture, entry memory, entry update, divide by 1000 in
// 16-bit digits by reciprocal multiply, result register. Depends on pset_pkg and pset_ram.
`default_nettype none

module pset_dp
  import pset_pkg::*;
#(
  parameter int TIMERS = TIMERS_DEF,
  localparam int AW = (TIMERS > 1) ? $clog2(TIMERS) : 1
) (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire ctl_cmd_t      cmd,
  output ctl_sts_t           sts,
  input  wire logic [AW-1:0] walk_addr,
  input  wire logic [3:0]    in_command,
  input  wire logic [5:0]    in_timer_index,
  input  wire logic [31:0]   in_elapsed_ns,
  input  wire logic signed [31:0] in_aux_amount,
  input  wire logic          in_accept,
  input  wire logic [47:0]   in_tick,
  input  wire logic [31:0]   in_ack_sequence,
  output logic               out_valid,
  output logic               out_ok,
  output logic [31:0]        out_sequence_res,
  output logic [31:0]        out_event_sample_sequence,
  output logic [47:0]        out_event_tick,
  output logic [38:0]        out_sample_us,
  output logic [31:0]        out_invocation_count,
  output logic signed [39:0] out_aux_count,
  output logic               out_event_available,
  output logic               out_event_overrun
);

  localparam int EW = $bits(entry_t);
  localparam logic [9:0]  DIVISOR  = 10'(NS_PER_US);
  // ceil(2^36 / 1000): exact quotient for every digit value below 1000 * 2^16
  localparam logic [26:0] RECIP    = 27'd68719477;
  localparam logic [1:0]  DIV_LAST = 2'(DIV_DIGITS - 1);

  // Captured command
  cmd_t        cmd_r;
  logic [5:0]  idx_r;
  logic [31:0] elapsed_r;
  logic [31:0] aux_r;
  logic        accept_r;
  logic [47:0] tick_r;
  logic [31:0] ack_r;

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      cmd_r     <= cmd_t'(in_command);
      idx_r     <= in_timer_index;
      elapsed_r <= in_elapsed_ns;
      aux_r     <= in_aux_amount;
      accept_r  <= in_accept;
      tick_r    <= in_tick;
      ack_r     <= in_ack_sequence;
    end
  end

  // Entry memory
  logic [AW-1:0] addr;
  logic [EW-1:0] rdata;
  entry_t        e, n;

  assign addr = cmd.use_walk ? walk_addr : AW'(idx_r);
  assign e    = entry_t'(rdata);

  pset_ram #(.WIDTH(EW), .DEPTH(TIMERS)) u_ram (
    .clk   (clk),
    .we    (cmd.wr_en),
    .re    (cmd.rd_en),
    .addr  (addr),
    .wdata (cmd.clr ? '0 : EW'(n)),
    .rdata (rdata)
  );

  // Divide by 1000, one 16-bit quotient digit a cycle, most significant first
  logic [47:0] num_r;
  logic [47:0] quo_r;
  logic [9:0]  rem_r;
  logic [1:0]  cnt_r;
  logic        div_busy_r, div_done_r;
  logic [25:0] dig;
  logic [15:0] dig_q;
  logic [9:0]  dig_rem;

  assign dig     = {rem_r, num_r[47:32]};
  assign dig_q   = 16'(({27'd0, dig} * {26'd0, RECIP}) >> 36);
  assign dig_rem = 10'(dig - (26'(dig_q) * 26'(DIVISOR)));

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      div_busy_r <= 1'b0;
      div_done_r <= 1'b0;
    end else if (cmd.div_start) begin
      div_busy_r <= 1'b1;
      div_done_r <= 1'b0;
    end else if (div_busy_r && (cnt_r == DIV_LAST)) begin
      div_busy_r <= 1'b0;
      div_done_r <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.div_start) begin
      num_r <= e.total_ns;
      rem_r <= '0;
      cnt_r <= '0;
    end else if (div_busy_r) begin
      cnt_r <= cnt_r + 1'b1;
      num_r <= {num_r[31:0], 16'd0};
      quo_r <= {quo_r[31:0], dig_q};
      rem_r <= dig_rem;
    end
  end

  // Status
  logic cmd_known;
  assign cmd_known = (cmd_r <= CMD_READEV);

  always_comb begin
    sts.all      = (cmd_r == CMD_LATCHALL);
    sts.known    = cmd_known && (sts.all || (32'(idx_r) < TIMERS));
    sts.need_div = accept_r &&
                   ((cmd_r == CMD_LATCH1) || ((cmd_r == CMD_LATCHALL) && e.registered));
    sts.div_done = div_done_r;
  end

  // Entry update and result
  logic [48:0] tot_sum;
  logic [40:0] aux_sum;
  logic        ok;

  assign tot_sum = {1'b0, e.total_ns} + {17'd0, elapsed_r};
  assign aux_sum = {e.pend_aux[39], e.pend_aux} + {{9{aux_r[31]}}, aux_r};

  always_comb begin
    n  = e;
    ok = 1'b1;
    unique case (cmd_r)
      CMD_REG:   n.registered = 1'b1;
      CMD_REGEV: n.event_registered = 1'b1;
      CMD_ACC: begin
        ok = e.registered;
        if (e.registered) begin
          n.total_ns = tot_sum[48] ? '1 : tot_sum[47:0];
          if (e.pend_inv != '1) begin
            n.pend_inv = e.pend_inv + 1'b1;
          end
        end
      end
      CMD_AUX: begin
        if (aux_sum[40] != aux_sum[39]) begin
          n.pend_aux = aux_sum[40] ? {1'b1, 39'd0} : {1'b0, {39{1'b1}}};
        end else begin
          n.pend_aux = aux_sum[39:0];
        end
      end
      CMD_LATCH1, CMD_LATCHALL: begin
        if ((cmd_r == CMD_LATCH1) || e.registered) begin
          n.pend_aux = '0;
          n.total_ns = '0;
          n.pend_inv = '0;
          if (accept_r) begin
            n.rec_seq = e.rec_seq + 1'b1;
            n.rec_us  = quo_r[38:0];
            n.rec_inv = e.pend_inv;
            n.rec_aux = e.pend_aux;
          end
        end
        if (!accept_r) begin
          n.armed    = 1'b0;
          n.min_tick = '0;
        end
      end
      CMD_ARM: begin
        ok = e.event_registered && !e.mbox_available && !e.mbox_overrun;
        if (ok) begin
          n.armed    = 1'b1;
          n.min_tick = tick_r;
        end
      end
      CMD_PUB: begin
        ok = 1'b0;
        if (e.mbox_available) begin
          n.mbox_overrun = 1'b1;
        end else if (e.event_registered && e.armed && !e.mbox_overrun &&
                     (tick_r >= e.min_tick)) begin
          ok                = 1'b1;
          n.mbox_seq        = e.mbox_seq + 1'b1;
          n.mbox_sample_seq = e.rec_seq;
          n.mbox_tick       = tick_r;
          n.mbox_us         = e.rec_us;
          n.mbox_inv        = e.rec_inv;
          n.mbox_aux        = e.rec_aux;
          n.mbox_available  = 1'b1;
          n.mbox_overrun    = 1'b0;
          n.armed           = 1'b0;
          n.min_tick        = '0;
        end
      end
      CMD_ACK: begin
        ok = e.mbox_available && (ack_r != '0) && (ack_r == e.mbox_seq);
        if (ok) begin
          n.mbox_available = 1'b0;
          n.mbox_overrun   = 1'b0;
        end
      end
      default: ok = 1'b1;
    endcase
  end

  // Result register: one-cycle strobe
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid <= 1'b0;
    end else begin
      out_valid <= cmd.emit;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit) begin
      out_ok                    <= cmd.emit_zero ? 1'b0 : ok;
      out_sequence_res          <= '0;
      out_event_sample_sequence <= '0;
      out_event_tick            <= '0;
      out_sample_us             <= '0;
      out_invocation_count      <= '0;
      out_aux_count             <= '0;
      out_event_available       <= 1'b0;
      out_event_overrun         <= 1'b0;
      if (!cmd.emit_zero && (cmd_r == CMD_READREC)) begin
        out_sequence_res     <= e.rec_seq;
        out_sample_us        <= e.rec_us;
        out_invocation_count <= e.rec_inv;
        out_aux_count        <= e.rec_aux;
      end
      if (!cmd.emit_zero && (cmd_r == CMD_READEV)) begin
        out_sequence_res          <= e.mbox_seq;
        out_event_sample_sequence <= e.mbox_sample_seq;
        out_event_tick            <= e.mbox_tick;
        out_sample_us             <= e.mbox_us;
        out_invocation_count      <= e.mbox_inv;
        out_aux_count             <= e.mbox_aux;
        out_event_available       <= e.mbox_available;
        out_event_overrun         <= e.mbox_overrun;
      end
    end
  end

endmodule

`default_nettype wire

// ----- src/profile_sample_event_table_core.sv -----
// Top level of the profile sample event table: controller plus datapath.
// Depends on pset_pkg, pset_ctrl, pset_dp (and pset_ram below it).
//
//   channel  | handshake              | payload
//   ---------+------------------------+-------------------------------------
//   input    | start, busy            | in_command .. in_ack_sequence
//   result   | out_valid (1 cycle)    | out_ok .. out_event_overrun
//
// A command that touches one entry runs decode, execute and write, then
// its result is registered; a latch with accept adds the three-digit
// divide by 1000. Latch-all walks the entry memory one entry at a time,
// dividing for each registered entry latched with accept, since the RAM
// has one port. After reset a clearing pass zeroes each entry, busy high.
// The result is shown for one cycle; the receiver cannot stall it.
`default_nettype none

module profile_sample_event_table_core
  import pset_pkg::*;
#(
  parameter int TIMERS = TIMERS_DEF
) (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               start,
  output logic                    busy,
  input  wire logic [3:0]         in_command,
  input  wire logic [5:0]         in_timer_index,
  input  wire logic [31:0]        in_elapsed_ns,
  input  wire logic signed [31:0] in_aux_amount,
  input  wire logic               in_accept,
  input  wire logic [47:0]        in_tick,
  input  wire logic [31:0]        in_ack_sequence,
  output logic                    out_valid,
  output logic                    out_ok,
  output logic [31:0]             out_sequence_res,
  output logic [31:0]             out_event_sample_sequence,
  output logic [47:0]             out_event_tick,
  output logic [38:0]             out_sample_us,
  output logic [31:0]             out_invocation_count,
  output logic signed [39:0]      out_aux_count,
  output logic                    out_event_available,
  output logic                    out_event_overrun
);

  localparam int AW = (TIMERS > 1) ? $clog2(TIMERS) : 1;

  ctl_cmd_t      cmd;
  ctl_sts_t      sts;
  logic [AW-1:0] walk_addr;

  pset_ctrl #(.TIMERS(TIMERS)) u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (start),
    .busy      (busy),
    .sts       (sts),
    .cmd       (cmd),
    .walk_addr (walk_addr)
  );

  pset_dp #(.TIMERS(TIMERS)) u_dp (
    .clk                       (clk),
    .rst_n                     (rst_n),
    .cmd                       (cmd),
    .sts                       (sts),
    .walk_addr                 (walk_addr),
    .in_command                (in_command),
    .in_timer_index            (in_timer_index),
    .in_elapsed_ns             (in_elapsed_ns),
    .in_aux_amount             (in_aux_amount),
    .in_accept                 (in_accept),
    .in_tick                   (in_tick),
    .in_ack_sequence           (in_ack_sequence),
    .out_valid                 (out_valid),
    .out_ok                    (out_ok),
    .out_sequence_res          (out_sequence_res),
    .out_event_sample_sequence (out_event_sample_sequence),
    .out_event_tick            (out_event_tick),
    .out_sample_us             (out_sample_us),
    .out_invocation_count      (out_invocation_count),
    .out_aux_count             (out_aux_count),
    .out_event_available       (out_event_available),
    .out_event_overrun         (out_event_overrun)
  );

endmodule

`default_nettype wire
